### rtl/fwk_pkg.sv
// ----------------------------------------------------------------------------
// fwk_pkg
// Shared widths, request codes and inter-module structs for the binary
// indexed tree block.
// ----------------------------------------------------------------------------
package fwk_pkg;

  localparam int unsigned TYPE_W  = 2;
  localparam int unsigned SIZE_W  = 11;   // slot index, size and rank fields
  localparam int unsigned IDX_W   = 12;   // walk index, room for i + lowbit(i)
  localparam int unsigned DELTA_W = 16;
  localparam int unsigned SUM_W   = 32;

  localparam logic [TYPE_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_PREFIX = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_SEARCH = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  // accepted input word
  typedef struct packed {
    logic [TYPE_W-1:0]  req_type;
    logic [SIZE_W-1:0]  slot_index;
    logic [DELTA_W-1:0] delta;
    logic [SIZE_W-1:0]  rank_k;
  } item_t;

  // one tree walk: add (walk up) or prefix sum (walk down)
  typedef struct packed {
    logic              valid;
    logic              is_add;
    logic [IDX_W-1:0]  idx;
    logic [SUM_W-1:0]  addend;
  } walk_req_t;

  typedef struct packed {
    logic              done;
    logic [SUM_W-1:0]  sum;
  } walk_rsp_t;

  typedef struct packed {
    logic              valid;
    logic [SUM_W-1:0]  value;
  } res_t;

  // lowest set bit of a walk index
  function automatic logic [IDX_W-1:0] low_bit(input logic [IDX_W-1:0] x);
    return x & (~x + 1'b1);
  endfunction

endpackage

### rtl/fenwick_tree_kth_free_search.sv
// ----------------------------------------------------------------------------
// fenwick_tree_kth_free_search
// Binary indexed tree of signed 32-bit counters with add, prefix sum and
// k-th free slot search requests.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (req_type, slot_index, delta, rank_k) are taken when
//   in_valid_i is high and in_stall_o low. Add requests give no result;
//   prefix and search requests give one result word on result_value_o,
//   taken when out_valid_o is high and out_stall_i low.
//   cfg_we_i writes active_size; the user must do this only while the
//   block is idle, as the block itself does not enforce it.
// Work, one word at a time (the node memory has one read port, so tree
// nodes are visited in turn):
//   add     : one read-modify-write per node on the upward path
//   prefix  : one read per set bit of the index, then the output register
//   search  : about log2(n)+1 probes, each a prefix walk of the probe
// After reset the node memory is zeroed by a clearing pass, during
// which in_stall_o is high. A stalled result sits in the output register
// while the next word is already accepted and worked on; that word's own
// result then waits until the register is free.
// ----------------------------------------------------------------------------
module fenwick_tree_kth_free_search #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fwk_pkg::SIZE_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [fwk_pkg::TYPE_W-1:0]   req_type_i,
  input  logic [fwk_pkg::SIZE_W-1:0]   slot_index_i,
  input  logic signed [fwk_pkg::DELTA_W-1:0] delta_i,
  input  logic [fwk_pkg::SIZE_W-1:0]   rank_k_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [fwk_pkg::SUM_W-1:0] result_value_o
);
  import fwk_pkg::*;

  logic [SIZE_W-1:0] active_size_q;
  logic [SIZE_W-1:0] n_eff;
  logic              out_valid_q, out_valid_d;
  logic [SUM_W-1:0]  out_data_q;
  logic              ready, start, out_free, load;
  item_t             item;
  walk_req_t         walk_req;
  walk_rsp_t         walk_rsp;
  logic              walk_idle;
  res_t              res;

  assign n_eff = (32'(active_size_q) < SLOTS) ? active_size_q : SIZE_W'(SLOTS);

  assign item.req_type   = req_type_i;
  assign item.slot_index = slot_index_i;
  assign item.delta      = delta_i;
  assign item.rank_k     = rank_k_i;

  assign in_stall_o = !ready;
  assign start      = in_valid_i && ready;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign load        = res.valid && out_free;
  assign out_valid_d = load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_size_q <= SIZE_RESET;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        active_size_q <= cfg_wdata_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= res.value;
    end
  end

  fwk_walk #(
    .SLOTS (SLOTS)
  ) u_walk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (walk_req),
    .n_i    (n_eff),
    .idle_o (walk_idle),
    .rsp_o  (walk_rsp)
  );

  fwk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .item_i      (item),
    .n_i         (n_eff),
    .ready_o     (ready),
    .walk_idle_i (walk_idle),
    .walk_req_o  (walk_req),
    .walk_rsp_i  (walk_rsp),
    .out_free_i  (out_free),
    .res_o       (res)
  );

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_data_q;

endmodule

### rtl/fwk_ram.sv
// ----------------------------------------------------------------------------
// fwk_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module fwk_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/fwk_walk.sv
// ----------------------------------------------------------------------------
// fwk_walk
// Tree walker around the node memory. Clears the memory after reset, then
// runs add walks (read-modify-write up the tree) and prefix walks
// (accumulate down the tree), one node per cycle.
// ----------------------------------------------------------------------------
module fwk_walk #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fwk_pkg::walk_req_t          req_i,
  input  logic [fwk_pkg::SIZE_W-1:0]  n_i,
  output logic                        idle_o,
  output fwk_pkg::walk_rsp_t          rsp_o
);
  import fwk_pkg::*;

  localparam int unsigned AW = $clog2(SLOTS);

  typedef enum logic [1:0] {W_CLEAR, W_IDLE, W_ADD, W_PFX} state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [SUM_W-1:0] addend_q, addend_d;
  logic [SUM_W-1:0] acc_q, acc_d;
  logic             done_q, done_d;
  logic [AW-1:0]    clr_q, clr_d;

  logic [IDX_W-1:0] n_ext, nxt_up, nxt_dn, rd_idx;
  logic             re, we;
  logic [AW-1:0]    waddr, raddr;
  logic [SUM_W-1:0] wdata, rdata;

  assign n_ext  = {1'b0, n_i};
  assign nxt_up = idx_q + low_bit(idx_q);
  assign nxt_dn = idx_q - low_bit(idx_q);
  // slot i lives at address i - 1
  assign raddr  = AW'(rd_idx - 1'b1);

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    addend_d = addend_q;
    acc_d    = acc_q;
    done_d   = 1'b0;
    clr_d    = clr_q;
    re       = 1'b0;
    rd_idx   = idx_q;
    we       = 1'b0;
    waddr    = AW'(idx_q - 1'b1);
    wdata    = rdata + addend_q;
    unique case (state_q)
      W_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(SLOTS - 1)) begin
          state_d = W_IDLE;
        end
      end
      W_IDLE: begin
        if (req_i.valid) begin
          if (req_i.is_add) begin
            if (req_i.idx != '0 && req_i.idx <= n_ext) begin
              re       = 1'b1;
              rd_idx   = req_i.idx;
              idx_d    = req_i.idx;
              addend_d = req_i.addend;
              state_d  = W_ADD;
            end else begin
              done_d = 1'b1;
            end
          end else begin
            acc_d = '0;
            if (req_i.idx == '0) begin
              done_d = 1'b1;
            end else begin
              re      = 1'b1;
              rd_idx  = req_i.idx;
              idx_d   = req_i.idx - low_bit(req_i.idx);
              state_d = W_PFX;
            end
          end
        end
      end
      W_ADD: begin
        // write back this node, fetch the parent; addresses always differ
        we = 1'b1;
        if (nxt_up <= n_ext) begin
          re     = 1'b1;
          rd_idx = nxt_up;
          idx_d  = nxt_up;
        end else begin
          done_d  = 1'b1;
          state_d = W_IDLE;
        end
      end
      W_PFX: begin
        acc_d = acc_q + rdata;
        if (idx_q == '0) begin
          done_d  = 1'b1;
          state_d = W_IDLE;
        end else begin
          re     = 1'b1;
          rd_idx = idx_q;
          idx_d  = nxt_dn;
        end
      end
      default: state_d = W_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= W_CLEAR;
      idx_q    <= '0;
      addend_q <= '0;
      acc_q    <= '0;
      done_q   <= 1'b0;
      clr_q    <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      addend_q <= addend_d;
      acc_q    <= acc_d;
      done_q   <= done_d;
      clr_q    <= clr_d;
    end
  end

  fwk_ram #(
    .WIDTH (SUM_W),
    .DEPTH (SLOTS)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign idle_o    = (state_q == W_IDLE);
  assign rsp_o.done = done_q;
  assign rsp_o.sum  = acc_q;

endmodule

### rtl/fwk_ctrl.sv
// ----------------------------------------------------------------------------
// fwk_ctrl
// Request sequencer: decodes a word, issues add / prefix walks, and runs the
// binary search for the k-th free slot as a series of prefix walks.
// ----------------------------------------------------------------------------
module fwk_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  fwk_pkg::item_t              item_i,
  input  logic [fwk_pkg::SIZE_W-1:0]  n_i,
  output logic                        ready_o,
  input  logic                        walk_idle_i,
  output fwk_pkg::walk_req_t          walk_req_o,
  input  fwk_pkg::walk_rsp_t          walk_rsp_i,
  input  logic                        out_free_i,
  output fwk_pkg::res_t               res_o
);
  import fwk_pkg::*;

  typedef enum logic [2:0] {C_IDLE, C_WALK, C_TEST, C_WAIT, C_OUT} state_e;

  state_e            state_q, state_d;
  logic              want_q, want_d;
  logic [IDX_W-1:0]  lo_q, lo_d, hi_q, hi_d, found_q, found_d, mid_q, mid_d;
  logic [SIZE_W-1:0] k_q, k_d;
  logic [SUM_W-1:0]  result_q, result_d;

  logic [IDX_W:0]    lo_hi;
  logic [IDX_W-1:0]  mid, n_ext, slot_ext;
  logic signed [SUM_W+1:0] free_cnt;
  logic              hit;

  assign n_ext    = {1'b0, n_i};
  assign slot_ext = {1'b0, item_i.slot_index};
  assign lo_hi    = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid      = lo_hi[IDX_W:1];
  // mid - prefix(mid), exact in 34 bits
  assign free_cnt = $signed({{(SUM_W + 2 - IDX_W){1'b0}}, mid_q})
                  - $signed({{2{walk_rsp_i.sum[SUM_W-1]}}, walk_rsp_i.sum});
  assign hit      = free_cnt >= $signed({{(SUM_W + 2 - SIZE_W){1'b0}}, k_q});

  always_comb begin
    state_d  = state_q;
    want_d   = want_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    found_d  = found_q;
    mid_d    = mid_q;
    k_d      = k_q;
    result_d = result_q;
    walk_req_o.valid  = 1'b0;
    walk_req_o.is_add = 1'b0;
    walk_req_o.idx    = mid;
    walk_req_o.addend = {{(SUM_W - DELTA_W){item_i.delta[DELTA_W-1]}}, item_i.delta};
    unique case (state_q)
      C_IDLE: begin
        if (start_i) begin
          case (item_i.req_type)
            REQ_ADD: begin
              walk_req_o.valid  = 1'b1;
              walk_req_o.is_add = 1'b1;
              walk_req_o.idx    = slot_ext;
              want_d  = 1'b0;
              state_d = C_WALK;
            end
            REQ_PREFIX: begin
              walk_req_o.valid = 1'b1;
              walk_req_o.idx   = (slot_ext > n_ext) ? n_ext : slot_ext;
              want_d  = 1'b1;
              state_d = C_WALK;
            end
            REQ_SEARCH: begin
              lo_d    = IDX_W'(1);
              hi_d    = n_ext;
              found_d = n_ext;
              k_d     = item_i.rank_k;
              state_d = C_TEST;
            end
            default: ;  // unused code: dropped
          endcase
        end
      end
      C_WALK: begin
        if (walk_rsp_i.done) begin
          result_d = walk_rsp_i.sum;
          state_d  = want_q ? C_OUT : C_IDLE;
        end
      end
      C_TEST: begin
        if (lo_q <= hi_q) begin
          walk_req_o.valid = 1'b1;
          walk_req_o.idx   = mid;
          mid_d   = mid;
          state_d = C_WAIT;
        end else begin
          result_d = {{(SUM_W - IDX_W){1'b0}}, found_q};
          state_d  = C_OUT;
        end
      end
      C_WAIT: begin
        if (walk_rsp_i.done) begin
          if (hit) begin
            found_d = mid_q;
            hi_d    = mid_q - 1'b1;
          end else begin
            lo_d = mid_q + 1'b1;
          end
          state_d = C_TEST;
        end
      end
      C_OUT: begin
        if (out_free_i) begin
          state_d = C_IDLE;
        end
      end
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= C_IDLE;
      want_q   <= 1'b0;
      lo_q     <= '0;
      hi_q     <= '0;
      found_q  <= '0;
      mid_q    <= '0;
      k_q      <= '0;
      result_q <= '0;
    end else begin
      state_q  <= state_d;
      want_q   <= want_d;
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      found_q  <= found_d;
      mid_q    <= mid_d;
      k_q      <= k_d;
      result_q <= result_d;
    end
  end

  assign ready_o     = (state_q == C_IDLE) && walk_idle_i;
  assign res_o.valid = (state_q == C_OUT);
  assign res_o.value = result_q;

endmodule

### tb/fenwick_tree_kth_free_search_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fenwick_tree_kth_free_search_checker
// Watches the config port and both word channels of the tree block. Keeps a
// private copy of the tree and the active size, predicts every prefix sum
// and k-th free slot answer, and compares the result words in order.
// ----------------------------------------------------------------------------
module fenwick_tree_kth_free_search_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fwk_pkg::SIZE_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [fwk_pkg::TYPE_W-1:0]  req_type_i,
  input  logic [fwk_pkg::SIZE_W-1:0]  slot_index_i,
  input  logic [fwk_pkg::DELTA_W-1:0] delta_i,
  input  logic [fwk_pkg::SIZE_W-1:0]  rank_k_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [fwk_pkg::SUM_W-1:0]   result_value_i,
  output int unsigned                 pending_o,
  output int unsigned                 fail_count_o
);
  import fwk_pkg::*;

  localparam int unsigned NODES = 1024;

  logic [SUM_W-1:0]  node_q [1:NODES];
  logic [SIZE_W-1:0] size_q;
  logic [SUM_W-1:0]  answer_q [$];

  function automatic int unsigned live_slots();
    return (size_q < NODES) ? int'(size_q) : NODES;
  endfunction

  // downward walk, index clipped to the live size
  function automatic logic [SUM_W-1:0] tree_prefix(input int unsigned idx);
    int unsigned      i;
    logic [SUM_W-1:0] acc;
    i   = (idx > live_slots()) ? live_slots() : idx;
    acc = '0;
    while (i > 0) begin
      acc = acc + node_q[i];
      i   = i - (i & (~i + 1));
    end
    return acc;
  endfunction

  function automatic void tree_add(input int unsigned idx, input logic [DELTA_W-1:0] d);
    int unsigned      i;
    logic [SUM_W-1:0] addend;
    addend = {{(SUM_W-DELTA_W){d[DELTA_W-1]}}, d};
    i      = idx;
    while (i >= 1 && i <= live_slots()) begin
      node_q[i] = node_q[i] + addend;
      i         = i + (i & (~i + 1));
    end
  endfunction

  // smallest slot with slot - prefix >= k, exact arithmetic; live size if none
  function automatic logic [SUM_W-1:0] kth_free_slot(input int unsigned k);
    longint lo, hi, mid, free_cnt;
    int     psum;
    int unsigned found;
    lo    = 1;
    hi    = live_slots();
    found = live_slots();
    while (lo <= hi) begin
      mid      = (lo + hi) / 2;
      psum     = int'(tree_prefix(int'(mid)));
      free_cnt = mid - longint'(psum);
      if (free_cnt >= longint'(k)) begin
        found = int'(mid);
        hi    = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return found;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [SUM_W-1:0] want;
    if (!rst_ni) begin
      for (int i = 1; i <= NODES; i++) node_q[i] = '0;
      size_q = SIZE_RESET;
      answer_q.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) size_q = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        if (answer_q.size() == 0) begin
          $error("result_value: expected no word, got %0d", $signed(result_value_i));
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = answer_q.pop_front();
          if (result_value_i !== want) begin
            $error("result_value: expected %0d, got %0d", $signed(want),
                   $signed(result_value_i));
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (req_type_i)
          REQ_ADD:    tree_add(32'(slot_index_i), delta_i);
          REQ_PREFIX: answer_q.push_back(tree_prefix(32'(slot_index_i)));
          REQ_SEARCH: answer_q.push_back(kth_free_slot(32'(rank_k_i)));
          default: ;
        endcase
      end
      pending_o <= answer_q.size();
    end
  end

endmodule

### tb/fenwick_tree_kth_free_search_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fenwick_tree_kth_free_search_tb
// Drives add, prefix and k-th free search words into the tree block over a
// series of active sizes, with bursty input and patterned output stalls,
// and reports the checker's verdict.
// ----------------------------------------------------------------------------
module fenwick_tree_kth_free_search_tb;
  import fwk_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned SETTLE_CYCLES   = 160;
  localparam int unsigned HOLD_OFF_CYCLES = 600;
  localparam int unsigned PHASE_WORDS     = 140;
  localparam int unsigned NUM_PHASES      = 10;
  localparam int unsigned HOLD_PHASE      = 5;
  localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [SIZE_W-1:0]         cfg_wdata;
  logic                      in_valid;
  logic                      in_stall;
  logic [TYPE_W-1:0]         req_type;
  logic [SIZE_W-1:0]         slot_index;
  logic signed [DELTA_W-1:0] delta;
  logic [SIZE_W-1:0]         rank_k;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [SUM_W-1:0]   result_value;
  int unsigned               pending;
  int unsigned               fail_count;
  logic                      hold_off_req;
  int unsigned               burst_left;

  // shrinks, growth and the register extremes, tree kept across phases
  logic [SIZE_W-1:0] phase_size [NUM_PHASES] = '{11'd1, 11'd0, 11'd2047, 11'd2,
    11'd300, 11'd1024, 11'd13, 11'd64, 11'd1000, 11'd1024};

  fenwick_tree_kth_free_search u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .req_type_i     (req_type),
    .slot_index_i   (slot_index),
    .delta_i        (delta),
    .rank_k_i       (rank_k),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_value_o (result_value)
  );

  fenwick_tree_kth_free_search_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .req_type_i     (req_type),
    .slot_index_i   (slot_index),
    .delta_i        (delta),
    .rank_k_i       (rank_k),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .result_value_i (result_value),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // result side: random stall patterns, plus one long hold-off on request
  initial begin : result_stall
    int unsigned span, pct;
    bit          hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        case ($urandom_range(0, 3))
          0:       pct = 0;
          1:       pct = 25;
          2:       pct = 60;
          default: pct = 90;
        endcase
        span = $urandom_range(10, 150);
        repeat (span) begin
          out_stall <= ($urandom_range(0, 99) < pct);
          @(posedge clk);
        end
      end
    end
  end

  function automatic item_t make_word(input logic [TYPE_W-1:0] t, input int s, input int d,
                                      input int k);
    item_t w;
    w.req_type   = t;
    w.slot_index = s[SIZE_W-1:0];
    w.delta      = d[DELTA_W-1:0];
    w.rank_k     = k[SIZE_W-1:0];
    return w;
  endfunction

  // input side works in bursts with random gaps between them
  task automatic send_word(input item_t w);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 32);
    end
    in_valid   <= 1'b1;
    req_type   <= w.req_type;
    slot_index <= w.slot_index;
    delta      <= w.delta;
    rank_k     <= w.rank_k;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // block idle: all answers back, then room for a trailing add to finish
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    item_t       w;
    int unsigned p, cnt, n, hi, roll;
    int          undo, part;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_valid     <= 1'b0;
    req_type     <= REQ_ADD;
    slot_index   <= '0;
    delta        <= '0;
    rank_k       <= '0;
    hold_off_req <= 1'b0;
    burst_left   = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // node memory clear pass
    do @(posedge clk); while (in_stall);

    write_size(11'd1024);
    send_word(make_word(REQ_ADD, 1, 32767, 0));
    send_word(make_word(REQ_ADD, 1024, -32768, 2047));
    send_word(make_word(REQ_ADD, 0, 100, 0));        // slot zero, ignored
    send_word(make_word(REQ_ADD, 1025, 5, 0));       // past the live size
    send_word(make_word(REQ_ADD, 2047, -1, 0));
    send_word(make_word(REQ_ADD, 512, 1, 0));
    send_word(make_word(REQ_ADD, 3, 1, 0));
    send_word(make_word(REQ_PREFIX, 0, 0, 0));
    send_word(make_word(REQ_PREFIX, 1, 0, 0));
    send_word(make_word(REQ_PREFIX, 2, 0, 0));
    send_word(make_word(REQ_PREFIX, 512, 0, 0));
    send_word(make_word(REQ_PREFIX, 1024, 0, 0));
    send_word(make_word(REQ_PREFIX, 2047, -1, 2047)); // saturates to the size
    send_word(make_word(REQ_SEARCH, 0, 0, 0));        // rank zero
    send_word(make_word(REQ_SEARCH, 0, 0, 1));
    send_word(make_word(REQ_SEARCH, 0, 0, 2));
    send_word(make_word(REQ_SEARCH, 0, 0, 1024));
    send_word(make_word(REQ_SEARCH, 2047, -1, 2047)); // no slot qualifies
    send_word(make_word(REQ_UNUSED, 2047, -1, 2047));
    send_word(make_word(REQ_ADD, 1, -32767, 0));
    send_word(make_word(REQ_ADD, 1024, 32767, 0));
    send_word(make_word(REQ_ADD, 1024, 1, 0));
    send_word(make_word(REQ_SEARCH, 0, 0, 1));
    send_word(make_word(REQ_PREFIX, 1023, 0, 0));

    for (p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_size(phase_size[p]);
      n  = (phase_size[p] > 1024) ? 1024 : phase_size[p];
      hi = (n == 0) ? 1 : n;
      if (p == HOLD_PHASE) hold_off_req <= 1'b1;
      cnt = 0;
      while (cnt < PHASE_WORDS) begin
        roll         = $urandom_range(0, 99);
        w.req_type   = REQ_ADD;
        w.slot_index = SIZE_W'($urandom);
        w.delta      = DELTA_W'($urandom);
        w.rank_k     = SIZE_W'($urandom);
        undo         = 0;
        if (roll < 30) begin
          // occupy or release a slot, as a k-th free user would
          w.slot_index = SIZE_W'($urandom_range(1, hi));
          w.delta      = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'h0001;
        end else if (roll < 50) begin
          w.req_type   = REQ_PREFIX;
          w.slot_index = SIZE_W'($urandom_range(0, n));
        end else if (roll < 80) begin
          w.req_type = REQ_SEARCH;
          w.rank_k   = SIZE_W'($urandom_range(0, n + 1));
        end else if (roll < 97) begin
          w.req_type = TYPE_W'($urandom_range(REQ_ADD, REQ_SEARCH));
          if (w.req_type == REQ_ADD) undo = -int'($signed(w.delta));
        end else begin
          w.req_type = REQ_UNUSED;
        end
        send_word(w);
        if (w.req_type != REQ_UNUSED) cnt++;
        // take a full-range delta back out so searches stay meaningful
        while (undo != 0) begin
          part     = (undo > 32767) ? 32767 : undo;
          w.delta  = part[DELTA_W-1:0];
          w.rank_k = SIZE_W'($urandom);
          send_word(w);
          undo = undo - part;
        end
      end
    end
    drain();

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
